@@ rtl/central_binomial_mod_assert.svh @@
// ----------------------------------------------------------------------------
// central_binomial_mod_assert
// Assertion helpers for the central binomial block.
// ----------------------------------------------------------------------------
// Each expects clk and rst_n in scope.
`ifndef CENTRAL_BINOMIAL_MOD_ASSERT_SVH
`define CENTRAL_BINOMIAL_MOD_ASSERT_SVH

// same-cycle implication
`define CBM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CBM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/cbm_pkg.sv @@
// ----------------------------------------------------------------------------
// cbm_pkg
// Shared widths, types and constants of the central binomial block.
// ----------------------------------------------------------------------------
`default_nettype none
package cbm_pkg;
    localparam int MOD_W = 30;
    localparam int NMAX_W = 32;
    localparam logic [MOD_W-1:0] MOD_RESET = 30'd1000000007;

    // word passed from front end to sequencer
    typedef struct packed {
        logic [NMAX_W-1:0] n;
        logic              mod_bad;
    } job_t;
endpackage
`default_nettype wire

@@ rtl/cbm_req_if.sv @@
// ----------------------------------------------------------------------------
// cbm_req_if
// Request channel: one count per word.
// ----------------------------------------------------------------------------
`default_nettype none
interface cbm_req_if #(parameter int N_WIDTH = 16);
    logic               valid;
    logic               ready;
    logic [N_WIDTH-1:0] count_n;
    modport source (output valid, output count_n, input ready);
    modport sink (input valid, input count_n, output ready);
endinterface
`default_nettype wire

@@ rtl/cbm_rsp_if.sv @@
// ----------------------------------------------------------------------------
// cbm_rsp_if
// Response channel: one result per word.
// ----------------------------------------------------------------------------
`default_nettype none
interface cbm_rsp_if;
    logic        valid;
    logic        ready;
    logic [29:0] result_value;
    modport source (output valid, output result_value, input ready);
    modport sink (input valid, input result_value, output ready);
endinterface
`default_nettype wire

@@ rtl/central_binomial_mod.sv @@
// Central binomial coefficient modulo a configured modulus. Each request word
// carries a count n; the response is sum over i of C(n,i)^2 = C(2n,n) mod the
// modulus (0 if the modulus is below two). Coefficients are built in turn by
// multiplying by n+1-i and by the inverse of i, found by extended Euclid.
// Each i takes five operations (two divisions and three modular multiplies)
// plus two per Euclid step (one division and one multiply), where the number
// of Euclid steps k for i is at most about 45 for 30-bit moduli. All of them
// run on a single shared divider and a single serial multiplier.
// A two-word queue and an output register let requests and responses stall
// independently.
// ----------------------------------------------------------------------------
// central_binomial_mod
// Top level: modulus register, front end, queue and sequencer.
// ----------------------------------------------------------------------------
`default_nettype none
module central_binomial_mod
    import cbm_pkg::*;
#(
    parameter int N_WIDTH = 16
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic [MOD_W-1:0] cfg_wdata,
    cbm_req_if.sink               req,
    cbm_rsp_if.source             rsp
);
    logic [MOD_W-1:0] modulus_reg;
    logic             f_valid;
    logic             f_ready;
    job_t             f_job;
    logic             q_valid;
    logic             q_ready;
    job_t             q_job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= MOD_RESET;
        end
        else if (cfg_we)
        begin
            modulus_reg <= cfg_wdata;
        end
    end

    cbm_front #(.N_WIDTH(N_WIDTH)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .modulus   (modulus_reg),
        .job_valid (f_valid),
        .job_ready (f_ready),
        .job       (f_job)
    );

    cbm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_job   (f_job),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_job    (q_job)
    );

    cbm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (q_valid),
        .job_ready (q_ready),
        .job       (q_job),
        .modulus   (modulus_reg),
        .rsp       (rsp)
    );
endmodule
`default_nettype wire

@@ rtl/cbm_front.sv @@
// ----------------------------------------------------------------------------
// cbm_front
// Accepts counts, flags an unusable modulus, holds one word for the queue.
// ----------------------------------------------------------------------------
`default_nettype none
module cbm_front
    import cbm_pkg::*;
#(
    parameter int N_WIDTH = 16
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    cbm_req_if.sink               req,
    input  wire logic [MOD_W-1:0] modulus,
    output      logic             job_valid,
    input  wire logic             job_ready,
    output      job_t             job
);
    logic valid_reg;
    job_t job_reg;

    assign req.ready = !valid_reg || job_ready;
    assign job_valid = valid_reg;
    assign job       = job_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.ready && req.valid)
        begin
            job_reg.n       <= NMAX_W'(req.count_n);
            job_reg.mod_bad <= (modulus < MOD_W'(2));
        end
    end
endmodule
`default_nettype wire

@@ rtl/cbm_queue.sv @@
// ----------------------------------------------------------------------------
// cbm_queue
// Two-entry queue between front end and sequencer.
// ----------------------------------------------------------------------------
`default_nettype none
module cbm_queue
    import cbm_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push_valid,
    output      logic push_ready,
    input  wire job_t push_job,
    output      logic pop_valid,
    input  wire logic pop_ready,
    output      job_t pop_job
);
    job_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push;
    logic       do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_job    = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end
endmodule
`default_nettype wire

@@ rtl/cbm_div.sv @@
// ----------------------------------------------------------------------------
// cbm_div
// Restoring divider, one quotient bit per cycle. Results hold until next start.
// ----------------------------------------------------------------------------
`default_nettype none
module cbm_div
    import cbm_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [NMAX_W-1:0] dividend,
    input  wire logic [MOD_W-1:0]  divisor,
    output      logic              done,
    output      logic [NMAX_W-1:0] quot,
    output      logic [MOD_W-1:0]  rem
);
    localparam int CNT_W = $clog2(NMAX_W + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [NMAX_W-1:0] dvd_reg;
    logic [MOD_W-1:0]  dsr_reg;
    logic [NMAX_W-1:0] quot_reg;
    logic [MOD_W-1:0]  rem_reg;
    logic [MOD_W:0]    shifted;
    logic              fits;

    assign shifted = {rem_reg, dvd_reg[NMAX_W-1]};
    assign fits    = (shifted >= {1'b0, dsr_reg});
    assign done    = done_reg;
    assign quot    = quot_reg;
    assign rem     = rem_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NMAX_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg  <= dividend;
            dsr_reg  <= divisor;
            quot_reg <= '0;
            rem_reg  <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg  <= {dvd_reg[NMAX_W-2:0], 1'b0};
            quot_reg <= {quot_reg[NMAX_W-2:0], fits};
            rem_reg  <= fits ? MOD_W'(shifted - {1'b0, dsr_reg}) : shifted[MOD_W-1:0];
        end
    end
endmodule
`default_nettype wire

@@ rtl/cbm_mulmod.sv @@
// ----------------------------------------------------------------------------
// cbm_mulmod
// Serial modular multiplier: double-and-add over the bits of a, MSB first.
// b must be below the modulus. Result holds until next start.
// ----------------------------------------------------------------------------
`default_nettype none
module cbm_mulmod
    import cbm_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [NMAX_W-1:0] a,
    input  wire logic [MOD_W-1:0]  b,
    input  wire logic [MOD_W-1:0]  modulus,
    output      logic              done,
    output      logic [MOD_W-1:0]  product
);
    localparam int CNT_W = $clog2(NMAX_W + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [NMAX_W-1:0] a_reg;
    logic [MOD_W-1:0]  b_reg;
    logic [MOD_W-1:0]  acc_reg;
    logic [MOD_W:0]    dbl;
    logic [MOD_W-1:0]  dbl_red;
    logic [MOD_W:0]    sum;
    logic [MOD_W-1:0]  acc_next;

    always_comb
    begin
        dbl     = {acc_reg, 1'b0};
        dbl_red = (dbl >= {1'b0, modulus}) ? MOD_W'(dbl - {1'b0, modulus})
                                           : dbl[MOD_W-1:0];
        sum     = {1'b0, dbl_red} + {1'b0, b_reg};
        if (a_reg[NMAX_W-1])
        begin
            acc_next = (sum >= {1'b0, modulus}) ? MOD_W'(sum - {1'b0, modulus})
                                                : sum[MOD_W-1:0];
        end
        else
        begin
            acc_next = dbl_red;
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NMAX_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            a_reg   <= {a_reg[NMAX_W-2:0], 1'b0};
            acc_reg <= acc_next;
        end
    end
endmodule
`default_nettype wire

@@ rtl/cbm_back.sv @@
// ----------------------------------------------------------------------------
// cbm_back
// Sequencer: walks i = 1..n, builds C(n,i) with the shared divider and
// modular multiplier, inverts i by extended Euclid, sums the squares.
// ----------------------------------------------------------------------------
`default_nettype none
`include "central_binomial_mod_assert.svh"
module cbm_back
    import cbm_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             job_valid,
    output      logic             job_ready,
    input  wire job_t             job,
    input  wire logic [MOD_W-1:0] modulus,
    cbm_rsp_if.source             rsp
);
    localparam logic [4:0] ST_IDLE   = 5'd0;
    localparam logic [4:0] ST_L_FACT = 5'd1;
    localparam logic [4:0] ST_W_FACT = 5'd2;
    localparam logic [4:0] ST_L_MCF  = 5'd3;
    localparam logic [4:0] ST_W_MCF  = 5'd4;
    localparam logic [4:0] ST_L_IMOD = 5'd5;
    localparam logic [4:0] ST_W_IMOD = 5'd6;
    localparam logic [4:0] ST_EUC    = 5'd7;
    localparam logic [4:0] ST_W_EDIV = 5'd8;
    localparam logic [4:0] ST_L_QT   = 5'd9;
    localparam logic [4:0] ST_W_QT   = 5'd10;
    localparam logic [4:0] ST_L_INV  = 5'd11;
    localparam logic [4:0] ST_W_INV  = 5'd12;
    localparam logic [4:0] ST_L_SQ   = 5'd13;
    localparam logic [4:0] ST_W_SQ   = 5'd14;
    localparam logic [4:0] ST_OUT    = 5'd15;

    logic [4:0]        state_reg;
    logic [4:0]        state_next;
    logic [NMAX_W-1:0] n_reg;
    logic [NMAX_W-1:0] i_reg;
    logic [MOD_W-1:0]  coef_reg;
    logic [MOD_W-1:0]  sum_reg;
    logic [MOD_W-1:0]  r0_reg;
    logic [MOD_W-1:0]  r1_reg;
    logic [MOD_W-1:0]  t0_reg;
    logic [MOD_W-1:0]  t1_reg;
    logic [MOD_W-1:0]  res_reg;
    logic [MOD_W-1:0]  out_data_reg;
    logic              out_valid_reg;

    logic              div_start;
    logic [NMAX_W-1:0] div_dvd;
    logic [MOD_W-1:0]  div_dsr;
    logic              div_done;
    logic [NMAX_W-1:0] div_quot;
    logic [MOD_W-1:0]  div_rem;
    logic              mul_start;
    logic [NMAX_W-1:0] mul_a;
    logic [MOD_W-1:0]  mul_b;
    logic              mul_done;
    logic [MOD_W-1:0]  mul_res;
    logic [MOD_W:0]    acc_sum;
    logic [MOD_W-1:0]  sum_red;
    logic [MOD_W-1:0]  t2;
    logic              out_free;

    cbm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dsr),
        .done     (div_done),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    cbm_mulmod u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .modulus (modulus),
        .done    (mul_done),
        .product (mul_res)
    );

    assign out_free  = !out_valid_reg || rsp.ready;
    assign job_ready = (state_reg == ST_IDLE);
    assign rsp.valid        = out_valid_reg;
    assign rsp.result_value = out_data_reg;

    always_comb
    begin
        acc_sum = {1'b0, sum_reg} + {1'b0, mul_res};
        sum_red = (acc_sum >= {1'b0, modulus}) ? MOD_W'(acc_sum - {1'b0, modulus})
                                               : acc_sum[MOD_W-1:0];
        // t0 - q*t1, kept in [0, m)
        t2 = (t0_reg >= mul_res) ? (t0_reg - mul_res)
                                 : MOD_W'({1'b0, t0_reg} + {1'b0, modulus} - {1'b0, mul_res});
    end

    always_comb
    begin
        div_start = 1'b0;
        div_dvd   = n_reg - i_reg + NMAX_W'(1);
        div_dsr   = modulus;
        mul_start = 1'b0;
        mul_a     = NMAX_W'(coef_reg);
        mul_b     = div_rem;
        case (state_reg)
            ST_L_FACT:
            begin
                div_start = 1'b1;
            end
            ST_L_MCF:
            begin
                mul_start = 1'b1;
            end
            ST_L_IMOD:
            begin
                div_start = 1'b1;
                div_dvd   = i_reg;
            end
            ST_EUC:
            begin
                div_start = (r1_reg != '0);
                div_dvd   = NMAX_W'(r0_reg);
                div_dsr   = r1_reg;
            end
            ST_L_QT:
            begin
                mul_start = 1'b1;
                mul_a     = div_quot;
                mul_b     = t1_reg;
            end
            ST_L_INV:
            begin
                mul_start = 1'b1;
                mul_b     = (r0_reg == MOD_W'(1)) ? t0_reg : MOD_W'(1);
            end
            ST_L_SQ:
            begin
                mul_start = 1'b1;
                mul_b     = coef_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    if (job.mod_bad || job.n == '0)
                    begin
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        state_next = ST_L_FACT;
                    end
                end
            end
            ST_L_FACT: state_next = ST_W_FACT;
            ST_W_FACT: state_next = div_done ? ST_L_MCF : ST_W_FACT;
            ST_L_MCF:  state_next = ST_W_MCF;
            ST_W_MCF:  state_next = mul_done ? ST_L_IMOD : ST_W_MCF;
            ST_L_IMOD: state_next = ST_W_IMOD;
            ST_W_IMOD: state_next = div_done ? ST_EUC : ST_W_IMOD;
            ST_EUC:    state_next = (r1_reg != '0) ? ST_W_EDIV : ST_L_INV;
            ST_W_EDIV: state_next = div_done ? ST_L_QT : ST_W_EDIV;
            ST_L_QT:   state_next = ST_W_QT;
            ST_W_QT:   state_next = mul_done ? ST_EUC : ST_W_QT;
            ST_L_INV:  state_next = ST_W_INV;
            ST_W_INV:  state_next = mul_done ? ST_L_SQ : ST_W_INV;
            ST_L_SQ:   state_next = ST_W_SQ;
            ST_W_SQ:
            begin
                if (mul_done)
                begin
                    state_next = (i_reg == n_reg) ? ST_OUT : ST_L_FACT;
                end
            end
            ST_OUT:    state_next = out_free ? ST_IDLE : ST_OUT;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_OUT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                n_reg    <= job.n;
                i_reg    <= NMAX_W'(1);
                coef_reg <= MOD_W'(1);
                sum_reg  <= MOD_W'(1);
                res_reg  <= job.mod_bad ? '0 : MOD_W'(1);
            end
            ST_W_MCF:
            begin
                if (mul_done)
                begin
                    coef_reg <= mul_res;
                end
            end
            ST_W_IMOD:
            begin
                if (div_done)
                begin
                    r0_reg <= modulus;
                    r1_reg <= div_rem;
                    t0_reg <= '0;
                    t1_reg <= MOD_W'(1);
                end
            end
            ST_W_QT:
            begin
                if (mul_done)
                begin
                    r0_reg <= r1_reg;
                    r1_reg <= div_rem;
                    t0_reg <= t1_reg;
                    t1_reg <= t2;
                end
            end
            ST_W_INV:
            begin
                if (mul_done)
                begin
                    coef_reg <= mul_res;
                end
            end
            ST_W_SQ:
            begin
                if (mul_done)
                begin
                    sum_reg <= sum_red;
                    res_reg <= sum_red;
                    i_reg   <= i_reg + NMAX_W'(1);
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    out_data_reg <= res_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    `CBM_ASSERT_NOW(a_div_done_waiting, div_done,
        state_reg == ST_W_FACT || state_reg == ST_W_IMOD || state_reg == ST_W_EDIV,
        "divider finished with no one waiting")
    `CBM_ASSERT_NOW(a_mul_done_waiting, mul_done,
        state_reg == ST_W_MCF || state_reg == ST_W_QT || state_reg == ST_W_INV ||
        state_reg == ST_W_SQ, "multiplier finished with no one waiting")
    `CBM_ASSERT_NOW(a_sum_reduced, state_reg == ST_L_SQ, sum_reg < modulus && coef_reg < modulus,
        "running sum or coefficient not reduced")
    `CBM_ASSERT_NEXT(a_euclid_shrinks, state_reg == ST_W_QT && mul_done, r1_reg < r0_reg,
        "Euclid remainder did not shrink")
endmodule
`default_nettype wire

@@ verif/central_binomial_mod_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// central_binomial_mod_tb
// Drives counts through the request channel under several moduli, including
// the extremes and the out-of-range ones, and checks every response word
// against a table value or a local computation of C(2n,n) mod the modulus.
// ----------------------------------------------------------------------------
module central_binomial_mod_tb;
    import cbm_pkg::*;

    localparam int WATCHDOG_LIMIT = 600000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int RAND_ITEMS     = 100;

    typedef struct {
        bit               wr_mod;
        logic [MOD_W-1:0] mod_val;
        logic [15:0]      n;
        bit               typed;
        logic [MOD_W-1:0] result;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [MOD_W-1:0] cfg_wdata;

    cbm_req_if #(.N_WIDTH(16)) req ();
    cbm_rsp_if rsp ();

    central_binomial_mod #(.N_WIDTH(16)) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .req      (req),
        .rsp      (rsp)
    );

    logic [MOD_W-1:0] cur_modulus;
    logic [MOD_W-1:0] pending_sums[$];
    int               fail_count;
    int               stall_cycles;
    bit               steady_tx;
    bit               steady_rx;

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // inverse of a mod m, 1 when not coprime
    function automatic longint unsigned mod_inverse(longint unsigned a, longint unsigned m);
        longint r0;
        longint r1;
        longint t0;
        longint t1;
        longint q;
        longint tmp;
        r0 = m;
        r1 = a % m;
        t0 = 0;
        t1 = 1;
        while (r1 != 0)
        begin
            q = r0 / r1;
            tmp = r0 - q * r1;
            r0 = r1;
            r1 = tmp;
            tmp = t0 - q * t1;
            t0 = t1;
            t1 = tmp;
        end
        if (r0 != 1)
            return 1;
        if (t0 < 0)
            t0 += m;
        return longint'(t0) % m;
    endfunction

    function automatic logic [MOD_W-1:0] central_binom(logic [15:0] n, logic [MOD_W-1:0] m);
        longint unsigned mm;
        longint unsigned coef;
        longint unsigned sum;
        longint unsigned k;
        mm = m;
        coef = 1;
        sum = 1;
        if (mm < 2)
            return '0;
        for (k = 1; k <= n; k++)
        begin
            coef = (coef * ((n + 1 - k) % mm)) % mm;
            coef = (coef * mod_inverse(k, mm)) % mm;
            sum = (sum + (coef * coef) % mm) % mm;
        end
        return sum[MOD_W-1:0];
    endfunction

    task automatic send_count(logic [15:0] n, bit typed, logic [MOD_W-1:0] result);
        while (!steady_tx && $urandom_range(0, 99) < 38)
        begin
            req.valid <= 1'b0;
            @(negedge clk);
        end
        req.valid <= 1'b1;
        req.count_n <= n;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        pending_sums.push_back(typed ? result : central_binom(n, cur_modulus));
        @(negedge clk);
    endtask

    task automatic wait_idle();
        req.valid <= 1'b0;
        while (pending_sums.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_modulus(logic [MOD_W-1:0] m);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_wdata <= m;
        @(negedge clk);
        cfg_we <= 1'b0;
        cur_modulus = m;
    endtask

    always @(negedge clk)
        rsp.ready <= steady_rx || ($urandom_range(0, 99) >= 38);

    // response check and watchdog
    always @(posedge clk)
    begin
        logic [MOD_W-1:0] want;
        if (rst_n)
        begin
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (rsp.valid && rsp.ready)
            begin
                if (pending_sums.size() == 0)
                begin
                    $error("unexpected word: result_value actual %0d", rsp.result_value);
                    fail_count++;
                end
                else
                begin
                    want = pending_sums.pop_front();
                    if (rsp.result_value !== want)
                    begin
                        $error("result_value: expected %0d actual %0d", want,
                               rsp.result_value);
                        fail_count++;
                    end
                end
            end
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    stim_row_t stim_table[] = '{
        '{0, 30'd0,          16'd0,     1, 30'd1},
        '{0, 30'd0,          16'd1,     1, 30'd2},
        '{0, 30'd0,          16'd2,     1, 30'd6},
        '{0, 30'd0,          16'd3,     1, 30'd20},
        '{0, 30'd0,          16'd4,     1, 30'd70},
        '{0, 30'd0,          16'd10,    1, 30'd184756},
        '{1, 30'd2,          16'd5,     0, 30'd0},
        '{0, 30'd0,          16'd0,     1, 30'd1},
        '{1, 30'h3FFFFFFF,   16'd0,     1, 30'd1},
        '{0, 30'd0,          16'd15,    0, 30'd0},
        '{1, 30'd0,          16'hFFFF,  1, 30'd0},
        '{0, 30'd0,          16'd0,     1, 30'd0},
        '{1, 30'd1,          16'hAAAA,  1, 30'd0},
        '{0, 30'd0,          16'h5555,  1, 30'd0},
        '{1, 30'd7,          16'd10,    0, 30'd0},   // i multiple of modulus
        '{1, 30'd6,          16'd9,     0, 30'd0},   // i sharing a factor
        '{1, 30'd1000000007, 16'd12,    0, 30'd0}
    };

    initial
    begin
        logic [MOD_W-1:0] m;
        logic [15:0]      n;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        req.valid = 1'b0;
        req.count_n = '0;
        rsp.ready = 1'b0;
        fail_count = 0;
        stall_cycles = 0;
        steady_tx = 1'b0;
        steady_rx = 1'b0;
        cur_modulus = MOD_RESET;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (stim_table[r])
        begin
            if (stim_table[r].wr_mod)
                write_modulus(stim_table[r].mod_val);
            send_count(stim_table[r].n, stim_table[r].typed, stim_table[r].result);
        end

        for (int k = 0; k < RAND_ITEMS; k++)
        begin
            if (k % 20 == 0)
            begin
                case ($urandom_range(0, 4))
                    0: m = MOD_W'($urandom_range(2, 50));
                    1: m = MOD_W'($urandom_range(0, 1));
                    2: m = 30'd65537;
                    default: m = MOD_W'($urandom_range(2, 30'h3FFFFFFF));
                endcase
                write_modulus(m);
            end
            steady_tx = (k >= 40 && k < 60);
            steady_rx = (k >= 40 && k < 60);
            if (k == 75)
                wait_idle();
            if (cur_modulus < 2)
                n = 16'($urandom_range(0, 16'hFFFF));
            else if ($urandom_range(0, 9) == 0)
                n = 16'($urandom_range(13, 30));
            else
                n = 16'($urandom_range(0, 12));
            send_count(n, 1'b0, '0);
        end

        wait_idle();
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
